// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent required in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/s2cd_pkg.sv =====
// constants, reciprocal factors, month table and the pipeline beat type
// for the seconds to calendar date converter; no dependencies
package s2cd_pkg;

	// calendar constants in seconds
	localparam logic [26:0] BLOCK_SEC = 27'd126230400;
	localparam logic [24:0] YEAR_SEC  = 25'd31536000;
	localparam logic [26:0] YEAR2_SEC = 27'd63072000;
	localparam logic [26:0] YEAR3_SEC = 27'd94608000;
	localparam logic [16:0] DAY_SEC   = 17'd86400;
	localparam logic [11:0] HOUR_SEC  = 12'd3600;
	localparam logic [5:0]  MIN_SEC   = 6'd60;

	// year digit offset
	localparam int BASE_YEAR_LOW_DIGITS = 1;
	localparam int YEAR_MOD = 100;
	localparam logic [8:0] BASE_OFS = 9'(BASE_YEAR_LOW_DIGITS % YEAR_MOD);
	localparam logic [8:0] MOD_ONE  = 9'(YEAR_MOD);
	localparam logic [8:0] MOD_TWO  = 9'(2 * YEAR_MOD);

	// reciprocals; each estimate is the true quotient or one below
	// block: (t >> 7) / 986175, factor 2^32 / 986175
	localparam logic [12:0] BLOCK_RECIP = 13'd4355;
	// day: (t >> 7) / 675, factor 2^24 / 675
	localparam logic [14:0] DAY_RECIP = 15'd24855;
	// hour: (s >> 4) / 225, factor 2^16 / 225
	localparam logic [8:0] HOUR_RECIP = 9'd291;
	// minute: (s >> 2) / 15, factor 2^12 / 15
	localparam logic [8:0] MIN_RECIP = 9'd273;

	// one item as it moves down the pipeline
	typedef struct packed {
		logic [31:0] t;
		logic [5:0]  qb;
		logic [27:0] rb;
		logic [7:0]  year;
		logic [6:0]  yd;
		logic        leap;
		logic [24:0] t2;
		logic [8:0]  day;
		logic [17:0] sod;
		logic [3:0]  month;
		logic [4:0]  dom;
		logic [4:0]  hour;
		logic [12:0] ms;
		logic [5:0]  minute;
		logic [6:0]  sec;
		logic [6:0]  cs;
	} s2cd_beat_t;

	// days before the first of each month
	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
		logic [8:0] d;
		case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = leap ? 9'd60 : 9'd59;
			4'd3:    d = leap ? 9'd91 : 9'd90;
			4'd4:    d = leap ? 9'd121 : 9'd120;
			4'd5:    d = leap ? 9'd152 : 9'd151;
			4'd6:    d = leap ? 9'd182 : 9'd181;
			4'd7:    d = leap ? 9'd213 : 9'd212;
			4'd8:    d = leap ? 9'd244 : 9'd243;
			4'd9:    d = leap ? 9'd274 : 9'd273;
			4'd10:   d = leap ? 9'd305 : 9'd304;
			4'd11:   d = leap ? 9'd335 : 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/s2cd_date.sv =====
// stages 2 to 8: four-year block, year in block, day of year, second of day
// depends on s2cd_pkg
module s2cd_date (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  s2cd_pkg::s2cd_beat_t in_beat,
	output logic                 out_valid,
	output s2cd_pkg::s2cd_beat_t out_beat
);

	s2cd_pkg::s2cd_beat_t beat_s2, beat_s3, beat_s4, beat_s5, beat_s6, beat_s7, beat_s8;
	s2cd_pkg::s2cd_beat_t nxt2, nxt3, nxt4, nxt5, nxt6, nxt7, nxt8;
	logic valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;

	logic [37:0] blk_prod;
	logic [31:0] blk_base;
	logic [31:0] blk_diff;
	logic [1:0]  yq;
	logic [26:0] yoff;
	logic [27:0] t2_full;
	logic [32:0] day_prod;
	logic [8:0]  ysum;
	logic [24:0] day_base;
	logic [24:0] sod_full;

	// block quotient estimate
	always_comb begin
		nxt2 = in_beat;
		blk_prod = 38'(in_beat.t[31:7]) * 38'(s2cd_pkg::BLOCK_RECIP);
		nxt2.qb = blk_prod[37:32];
	end

	// remainder against the estimate
	always_comb begin
		nxt3 = beat_s2;
		blk_base = 32'(beat_s2.qb) * 32'(s2cd_pkg::BLOCK_SEC);
		blk_diff = beat_s2.t - blk_base;
		nxt3.rb = blk_diff[27:0];
	end

	// block correction
	always_comb begin
		nxt4 = beat_s3;
		if (beat_s3.rb >= 28'(s2cd_pkg::BLOCK_SEC)) begin
			nxt4.qb = beat_s3.qb + 6'd1;
			nxt4.rb = beat_s3.rb - 28'(s2cd_pkg::BLOCK_SEC);
		end
	end

	// year in block, leap year last, clamped at three
	always_comb begin
		nxt5 = beat_s4;
		if (beat_s4.rb >= 28'(s2cd_pkg::YEAR3_SEC)) begin
			yq = 2'd3;
			yoff = s2cd_pkg::YEAR3_SEC;
		end else if (beat_s4.rb >= 28'(s2cd_pkg::YEAR2_SEC)) begin
			yq = 2'd2;
			yoff = s2cd_pkg::YEAR2_SEC;
		end else if (beat_s4.rb >= 28'(s2cd_pkg::YEAR_SEC)) begin
			yq = 2'd1;
			yoff = 27'(s2cd_pkg::YEAR_SEC);
		end else begin
			yq = 2'd0;
			yoff = 27'd0;
		end
		t2_full = beat_s4.rb - 28'(yoff);
		nxt5.t2 = t2_full[24:0];
		nxt5.year = {beat_s4.qb, 2'b00} + 8'(yq);
		nxt5.leap = (yq == 2'd3);
	end

	// day estimate and two-digit year
	always_comb begin
		nxt6 = beat_s5;
		day_prod = 33'(beat_s5.t2[24:7]) * 33'(s2cd_pkg::DAY_RECIP);
		nxt6.day = day_prod[32:24];
		ysum = 9'(beat_s5.year) + s2cd_pkg::BASE_OFS;
		if (ysum >= s2cd_pkg::MOD_TWO) begin
			nxt6.yd = 7'(ysum - s2cd_pkg::MOD_TWO);
		end else if (ysum >= s2cd_pkg::MOD_ONE) begin
			nxt6.yd = 7'(ysum - s2cd_pkg::MOD_ONE);
		end else begin
			nxt6.yd = ysum[6:0];
		end
	end

	// second of day against the estimate
	always_comb begin
		nxt7 = beat_s6;
		day_base = 25'(beat_s6.day) * 25'(s2cd_pkg::DAY_SEC);
		sod_full = beat_s6.t2 - day_base;
		nxt7.sod = sod_full[17:0];
	end

	// day correction
	always_comb begin
		nxt8 = beat_s7;
		if (beat_s7.sod >= 18'(s2cd_pkg::DAY_SEC)) begin
			nxt8.day = beat_s7.day + 9'd1;
			nxt8.sod = beat_s7.sod - 18'(s2cd_pkg::DAY_SEC);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		beat_s2 <= nxt2;
		beat_s3 <= nxt3;
		beat_s4 <= nxt4;
		beat_s5 <= nxt5;
		beat_s6 <= nxt6;
		beat_s7 <= nxt7;
		beat_s8 <= nxt8;
	end

	assign out_valid = valid_s8;
	assign out_beat  = beat_s8;

endmodule

// ===== rtl/s2cd_tod.sv =====
// stages 9 to 14: month and day of month, hour, minute and second
// depends on s2cd_pkg
module s2cd_tod (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  s2cd_pkg::s2cd_beat_t in_beat,
	output logic                 out_valid,
	output s2cd_pkg::s2cd_beat_t out_beat
);

	s2cd_pkg::s2cd_beat_t beat_s9, beat_s10, beat_s11, beat_s12, beat_s13, beat_s14;
	s2cd_pkg::s2cd_beat_t nxt9, nxt10, nxt11, nxt12, nxt13, nxt14;
	logic valid_s9, valid_s10, valid_s11, valid_s12, valid_s13, valid_s14;

	logic [8:0]  day1_a;
	logic [8:0]  day1_b;
	logic [8:0]  dom_full;
	logic [20:0] hr_prod;
	logic [16:0] hr_base;
	logic [16:0] ms_full;
	logic [18:0] mn_prod;
	logic [11:0] mn_base;
	logic [11:0] sec_full;

	// month from the cumulative table; hour estimate
	always_comb begin
		nxt9 = in_beat;
		day1_a = in_beat.day + 9'd1;
		nxt9.month = 4'd1;
		for (int i = 1; i < 12; i++) begin
			if (s2cd_pkg::cum_days(in_beat.leap, 4'(i)) < day1_a) begin
				nxt9.month = 4'(i + 1);
			end
		end
		hr_prod = 21'(in_beat.sod[16:4]) * 21'(s2cd_pkg::HOUR_RECIP);
		nxt9.hour = hr_prod[20:16];
	end

	// day of month; remainder against the hour estimate
	always_comb begin
		nxt10 = beat_s9;
		day1_b = beat_s9.day + 9'd1;
		dom_full = day1_b - s2cd_pkg::cum_days(beat_s9.leap, beat_s9.month - 4'd1);
		nxt10.dom = dom_full[4:0];
		hr_base = 17'(beat_s9.hour) * 17'(s2cd_pkg::HOUR_SEC);
		ms_full = beat_s9.sod[16:0] - hr_base;
		nxt10.ms = ms_full[12:0];
	end

	// hour correction
	always_comb begin
		nxt11 = beat_s10;
		if (beat_s10.ms >= 13'(s2cd_pkg::HOUR_SEC)) begin
			nxt11.hour = beat_s10.hour + 5'd1;
			nxt11.ms = beat_s10.ms - 13'(s2cd_pkg::HOUR_SEC);
		end
	end

	// minute estimate
	always_comb begin
		nxt12 = beat_s11;
		mn_prod = 19'(beat_s11.ms[11:2]) * 19'(s2cd_pkg::MIN_RECIP);
		nxt12.minute = mn_prod[17:12];
	end

	// second against the minute estimate
	always_comb begin
		nxt13 = beat_s12;
		mn_base = 12'(beat_s12.minute) * 12'(s2cd_pkg::MIN_SEC);
		sec_full = beat_s12.ms[11:0] - mn_base;
		nxt13.sec = sec_full[6:0];
	end

	// minute correction
	always_comb begin
		nxt14 = beat_s13;
		if (beat_s13.sec >= 7'(s2cd_pkg::MIN_SEC)) begin
			nxt14.minute = beat_s13.minute + 6'd1;
			nxt14.sec = beat_s13.sec - 7'(s2cd_pkg::MIN_SEC);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
		end else begin
			valid_s9  <= in_valid;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		beat_s9  <= nxt9;
		beat_s10 <= nxt10;
		beat_s11 <= nxt11;
		beat_s12 <= nxt12;
		beat_s13 <= nxt13;
		beat_s14 <= nxt14;
	end

	assign out_valid = valid_s14;
	assign out_beat  = beat_s14;

endmodule

// ===== rtl/seconds_to_calendar_date.sv =====
// top level: zone offset register, input stage and the two pipeline halves
// depends on s2cd_pkg, s2cd_date, s2cd_tod and assert_macros.svh
//
// channel   direction  handshake            payload
// cfg       in         cfg_we               cfg_wdata (zone offset, hours)
// command   in         start, busy          seconds_count, centiseconds_in
// result    out        done (one cycle)     year_digits .. centiseconds_out
//
// one beat accepted every cycle; busy is always low
// results pass the input stage and the chain of reciprocal multiply, subtract and
// correct stages for block, day, hour and minute
// arst_n clears the zone offset and all valid bits; payload is not reset
// results are strobed once and cannot be held off
`include "assert_macros.svh"

module seconds_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] seconds_count,
	input  logic [6:0]  centiseconds_in,
	output logic        done,
	output logic [6:0]  year_digits,
	output logic [3:0]  month_number,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour_of_day,
	output logic [5:0]  minute_of_hour,
	output logic [5:0]  second_of_minute,
	output logic [6:0]  centiseconds_out
);

	logic [31:0] shift_q;
	logic [31:0] zone_ext;
	logic        valid_s1;
	s2cd_pkg::s2cd_beat_t beat_s1;
	s2cd_pkg::s2cd_beat_t nxt1;
	logic        date_valid;
	s2cd_pkg::s2cd_beat_t date_beat;
	s2cd_pkg::s2cd_beat_t res_beat;

	assign busy = 1'b0;

	// zone offset kept as a wrapped shift in seconds
	assign zone_ext = {{26{cfg_wdata[5]}}, cfg_wdata};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 32'd0;
		end else if (cfg_we) begin
			shift_q <= zone_ext * 32'(s2cd_pkg::HOUR_SEC);
		end
	end

	// input stage: apply the zone shift
	always_comb begin
		nxt1 = '0;
		nxt1.t = seconds_count + shift_q;
		nxt1.cs = centiseconds_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		beat_s1 <= nxt1;
	end

	// calendar split
	s2cd_date u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_beat   (beat_s1),
		.out_valid (date_valid),
		.out_beat  (date_beat)
	);

	// month and time of day
	s2cd_tod u_tod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (date_valid),
		.in_beat   (date_beat),
		.out_valid (done),
		.out_beat  (res_beat)
	);

	// result ports
	assign year_digits      = res_beat.yd;
	assign month_number     = res_beat.month;
	assign day_of_month     = res_beat.dom;
	assign hour_of_day      = res_beat.hour;
	assign minute_of_hour   = res_beat.minute;
	assign second_of_minute = res_beat.sec[5:0];
	assign centiseconds_out = res_beat.cs;

	// checks
	`ASSERT_CLK(a_done_latency, clk, arst_n, done |-> $past(start, 14), "result without command")
	`ASSERT_CLK(a_date_range, clk, arst_n, done |-> (month_number >= 4'd1 && month_number <= 4'd12 && day_of_month >= 5'd1 && day_of_month <= 5'd31 && year_digits <= 7'd99), "date out of range")
	`ASSERT_CLK(a_time_range, clk, arst_n, done |-> (hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 && second_of_minute <= 6'd59), "time out of range")
	`ASSERT_NEXT(a_cs_pass, clk, arst_n, valid_s1, beat_s1.cs == $past(centiseconds_in), "centiseconds not captured")

endmodule

// ===== sim/calendar_date_checker.sv =====
// checker for the seconds to calendar date converter: predicts each date from the
// accepted seconds count and the zone offset it tracks, and compares result beats
// stand-alone; watches the block's ports only
module calendar_date_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_wdata,
	input  logic              start,
	input  logic              busy,
	input  logic [31:0]       seconds_count,
	input  logic [6:0]        centiseconds_in,
	input  logic              done,
	input  logic [6:0]        year_digits,
	input  logic [3:0]        month_number,
	input  logic [4:0]        day_of_month,
	input  logic [4:0]        hour_of_day,
	input  logic [5:0]        minute_of_hour,
	input  logic [5:0]        second_of_minute,
	input  logic [6:0]        centiseconds_out,
	output int unsigned       mismatch_total,
	output int unsigned       dates_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BLOCK_SECONDS = 126230400;
	localparam int unsigned YEAR_SECONDS  = 31536000;
	localparam int unsigned DAY_SECONDS   = 86400;
	localparam int unsigned HOUR_SECONDS  = 3600;
	localparam int unsigned MINUTE_SECONDS = 60;
	localparam int unsigned BASE_YEAR     = 1;

	// days before the first of each month
	localparam int unsigned PLAIN_DAYS [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	localparam int unsigned LEAP_DAYS [12] =
		'{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};

	typedef struct {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [6:0] centis;
	} calendar_date_t;

	calendar_date_t    expected_dates [$];
	logic signed [5:0] zone_hours;

	initial mismatch_total = 0;
	initial dates_pending = 0;

	function automatic calendar_date_t predict_calendar_date(input logic [31:0] secs,
			input logic [6:0] centis, input logic signed [5:0] zone);
		calendar_date_t d;
		logic [31:0]    t;
		int unsigned    yr, yq, day, sod, m, first_day;
		logic           leap;
		// shift by the zone, wrapping at 32 bits
		t = secs + 32'(int'(zone) * int'(HOUR_SECONDS));
		yr = (t / BLOCK_SECONDS) * 4;
		t = t % BLOCK_SECONDS;
		// the fourth year of a block is the leap year and takes the extra day
		yq = t / YEAR_SECONDS;
		if (yq > 3)
			yq = 3;
		yr += yq;
		t -= yq * YEAR_SECONDS;
		leap = (yr % 4) == 3;
		day = t / DAY_SECONDS + 1;
		sod = t % DAY_SECONDS;
		// walk back to the month whose first day is not after this day
		m = 11;
		first_day = leap ? LEAP_DAYS[m] : PLAIN_DAYS[m];
		while (m > 0 && day <= first_day) begin
			m--;
			first_day = leap ? LEAP_DAYS[m] : PLAIN_DAYS[m];
		end
		d.year   = 7'((yr + BASE_YEAR) % 100);
		d.month  = 4'(m + 1);
		d.day    = 5'(day - first_day);
		d.hour   = 5'(sod / HOUR_SECONDS);
		d.minute = 6'((sod % HOUR_SECONDS) / MINUTE_SECONDS);
		d.second = 6'(sod % MINUTE_SECONDS);
		d.centis = centis;
		return d;
	endfunction

	task automatic compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			mismatch_total++;
		end
	endtask

	// compare result beats, then queue the prediction for a new command beat
	always @(posedge clk or negedge arst_n) begin
		calendar_date_t want;
		if (!arst_n) begin
			zone_hours = '0;
			expected_dates.delete();
		end else begin
			if (done) begin
				if (expected_dates.size() == 0) begin
					$error("result beat with no expected date");
					mismatch_total++;
				end else begin
					want = expected_dates.pop_front();
					compare_field("year_digits", want.year, year_digits);
					compare_field("month_number", want.month, month_number);
					compare_field("day_of_month", want.day, day_of_month);
					compare_field("hour_of_day", want.hour, hour_of_day);
					compare_field("minute_of_hour", want.minute, minute_of_hour);
					compare_field("second_of_minute", want.second, second_of_minute);
					compare_field("centiseconds_out", want.centis, centiseconds_out);
				end
			end
			if (start && !busy)
				expected_dates.push_back(predict_calendar_date(seconds_count,
					centiseconds_in, zone_hours));
			if (cfg_we)
				zone_hours = cfg_wdata;
		end
		dates_pending = expected_dates.size();
	end

endmodule

// ===== sim/seconds_to_calendar_date_test.sv =====
// top of the seconds to calendar date testbench: clock, reset, zone writes and
// command beats; depends on seconds_to_calendar_date and calendar_date_checker
module seconds_to_calendar_date_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BLOCK_SECONDS = 126230400;
	localparam int unsigned YEAR_SECONDS  = 31536000;
	localparam int unsigned DAY_SECONDS   = 86400;
	localparam int unsigned MONTH_START [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	localparam int PHASE_ITEMS = 80;
	localparam int IDLE_PLAN [3] = '{0, 64, 6};

	// directed counts: range ends, year ends, leap day, clamped last leap-year day
	localparam logic [31:0] EDGE_SECONDS [18] = '{
		32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
		32'h5555_5555, 32'd5097599, 32'd5097600, 32'd31449600, 32'd31535999,
		32'd31536000, 32'd94607999, 32'd94608000, 32'd99705600, 32'd99791999,
		32'd99792000, 32'd126144000, 32'd126230399
	};
	localparam logic [6:0] EDGE_CENTIS [18] = '{
		7'd0, 7'd99, 7'd127, 7'd100, 7'd85, 7'd42, 7'd1, 7'd64, 7'd27, 7'd98,
		7'd50, 7'd31, 7'd0, 7'd12, 7'd99, 7'd3, 7'd77, 7'd120
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [5:0]  cfg_wdata = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] seconds_count = '0;
	logic [6:0]  centiseconds_in = '0;
	logic        done;
	logic [6:0]  year_digits;
	logic [3:0]  month_number;
	logic [4:0]  day_of_month;
	logic [4:0]  hour_of_day;
	logic [5:0]  minute_of_hour;
	logic [5:0]  second_of_minute;
	logic [6:0]  centiseconds_out;
	int unsigned mismatch_total;
	int unsigned dates_pending;

	always #6 clk = ~clk;

	seconds_to_calendar_date DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.start            (start),
		.busy             (busy),
		.seconds_count    (seconds_count),
		.centiseconds_in  (centiseconds_in),
		.done             (done),
		.year_digits      (year_digits),
		.month_number     (month_number),
		.day_of_month     (day_of_month),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.centiseconds_out (centiseconds_out)
	);

	calendar_date_checker date_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.start            (start),
		.busy             (busy),
		.seconds_count    (seconds_count),
		.centiseconds_in  (centiseconds_in),
		.done             (done),
		.year_digits      (year_digits),
		.month_number     (month_number),
		.day_of_month     (day_of_month),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.centiseconds_out (centiseconds_out),
		.mismatch_total   (mismatch_total),
		.dates_pending    (dates_pending)
	);

	// present one command beat and hold it until accepted
	task automatic send_timestamp(input logic [31:0] secs, input logic [6:0] centis);
		logic stalled;
		start <= 1'b1;
		seconds_count <= secs;
		centiseconds_in <= centis;
		do begin
			@(negedge clk);
			stalled = busy;
			@(posedge clk);
		end while (stalled);
	endtask

	// drop start and wait until every expected date has come back
	task automatic drain_dates();
		start <= 1'b0;
		do @(negedge clk); while (dates_pending != 0);
		@(posedge clk);
	endtask

	task automatic write_zone(input int hours);
		drain_dates();
		cfg_we <= 1'b1;
		cfg_wdata <= 6'(hours);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// counts biased toward month, year and block boundaries and the top of the range
	function automatic logic [31:0] pick_seconds();
		int unsigned sel, blk, yr, mon, base;
		sel = $urandom_range(9);
		blk = $urandom_range(34);
		yr = $urandom_range(3);
		mon = $urandom_range(11);
		base = blk * BLOCK_SECONDS;
		case (sel)
			0, 1, 2: return $urandom();
			8: return 32'hFFFF_FFFF - $urandom_range(200000);
			9: return 32'(base + 4 * YEAR_SECONDS - DAY_SECONDS
				+ $urandom_range(2 * DAY_SECONDS));
			default: return 32'(base + yr * YEAR_SECONDS + MONTH_START[mon] * DAY_SECONDS
				- 3 * DAY_SECONDS / 2 + $urandom_range(3 * DAY_SECONDS));
		endcase
	endfunction

	function automatic logic [6:0] pick_centis();
		if ($urandom_range(9) < 8)
			return 7'($urandom_range(99));
		return 7'($urandom_range(127, 100));
	endfunction

	// stimulus
	initial begin
		int zone_plan [8];
		int idle_pct;
		zone_plan = '{-24, 24, -32, 31, -1, 9, 0, 0};
		zone_plan[6] = int'($urandom_range(63)) - 32;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats at the reset zone
		foreach (EDGE_SECONDS[i])
			send_timestamp(EDGE_SECONDS[i], EDGE_CENTIS[i]);

		// a negative zone pulls counts near zero below zero
		write_zone(-1);
		send_timestamp(32'd0, 7'd5);
		send_timestamp(32'd3599, 7'd99);
		send_timestamp(32'd3600, 7'd0);

		// random phases, each with its own zone and sender idling
		for (int p = 0; p < 8; p++) begin
			write_zone(zone_plan[p]);
			idle_pct = IDLE_PLAN[p % 3];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2)
					drain_dates();
				while (int'($urandom_range(99)) < idle_pct) begin
					start <= 1'b0;
					seconds_count <= $urandom();
					centiseconds_in <= 7'($urandom());
					@(posedge clk);
				end
				send_timestamp(pick_seconds(), pick_centis());
			end
		end

		drain_dates();
		repeat (30) @(posedge clk);
		@(negedge clk);
		if (mismatch_total == 0 && dates_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
